// ===== rtl/bdqs_pkg.sv =====
`default_nettype none

package bdqs_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int KEY_W      = 32;
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 6;
    localparam int OCC_W      = 7;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;

    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_TAIL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd6;

    localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STS_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHL,
        CELL_SHR,
        CELL_LOAD,
        CELL_MARK,
        CELL_SWAP
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic                     phase;
        logic signed [KEY_W-1:0]  key;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/bdqs_cell.sv =====
`default_nettype none

module bdqs_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  wire logic                               clk,
    input  wire bdqs_pkg::cell_ctl_t                ctl,
    input  wire logic [CNT_W-1:0]                   count,
    input  wire logic signed [bdqs_pkg::KEY_W-1:0]  left_data,
    input  wire logic                               left_dead,
    input  wire logic signed [bdqs_pkg::KEY_W-1:0]  right_data,
    input  wire logic                               right_dead,
    output logic signed [bdqs_pkg::KEY_W-1:0]       data,
    output logic                                    dead
);

    localparam logic IS_ODD = 1'(IDX % 2);

    logic signed [bdqs_pkg::KEY_W-1:0] data_reg;
    logic                              dead_reg;

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            bdqs_pkg::CELL_HOLD:
            begin
            end
            bdqs_pkg::CELL_SHL:
            begin
                data_reg <= right_data;
            end
            bdqs_pkg::CELL_SHR:
            begin
                data_reg <= left_data;
            end
            bdqs_pkg::CELL_LOAD:
            begin
                if (count == CNT_W'(IDX))
                begin
                    data_reg <= ctl.key;
                end
            end
            bdqs_pkg::CELL_MARK:
            begin
                dead_reg <= (CNT_W'(IDX) >= count) || (data_reg == ctl.key);
            end
            bdqs_pkg::CELL_SWAP:
            begin
                // odd-even transposition: live entries bubble toward the head
                if (IS_ODD == ctl.phase)
                begin
                    if (dead_reg && !right_dead)
                    begin
                        data_reg <= right_data;
                        dead_reg <= right_dead;
                    end
                end
                else
                begin
                    if (left_dead && !dead_reg)
                    begin
                        data_reg <= left_data;
                        dead_reg <= left_dead;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign data = data_reg;
    assign dead = dead_reg;

endmodule

`default_nettype wire

// ===== rtl/bdqs_chain.sv =====
`default_nettype none

module bdqs_chain #(
    parameter int CAPACITY = bdqs_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                               clk,
    input  wire bdqs_pkg::cell_ctl_t                ctl,
    input  wire logic [CNT_W-1:0]                   count,
    output logic signed [bdqs_pkg::KEY_W-1:0]       head_data,
    output logic [CNT_W-1:0]                        kept
);

    logic signed [bdqs_pkg::KEY_W-1:0] cell_data [CAPACITY];
    logic                              cell_dead [CAPACITY];
    logic [CAPACITY-1:0]               edge_hit;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [bdqs_pkg::KEY_W-1:0] l_data;
        logic                              l_dead;
        logic signed [bdqs_pkg::KEY_W-1:0] r_data;
        logic                              r_dead;

        if (i == 0)
        begin : g_first
            assign l_data = ctl.key;
            assign l_dead = 1'b0;
        end
        else
        begin : g_mid_l
            assign l_data = cell_data[i-1];
            assign l_dead = cell_dead[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign r_data = cell_data[0];
            assign r_dead = 1'b1;
        end
        else
        begin : g_mid_r
            assign r_data = cell_data[i+1];
            assign r_dead = cell_dead[i+1];
        end

        bdqs_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .count      (count),
            .left_data  (l_data),
            .left_dead  (l_dead),
            .right_data (r_data),
            .right_dead (r_dead),
            .data       (cell_data[i]),
            .dead       (cell_dead[i])
        );

        // live-to-dead boundary after compaction
        assign edge_hit[i] = !cell_dead[i] && r_dead;
    end

    always_comb
    begin
        kept = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (edge_hit[i])
            begin
                kept = kept | CNT_W'(i + 1);
            end
        end
    end

    assign head_data = cell_data[0];

endmodule

`default_nettype wire

// ===== rtl/bounded_deque_search_engine.sv =====
// Insert, delete head, clear, delete on empty: the accepted beat goes through EXEC and WB to the result register.
// Delete tail, find: EXEC, then one full rotation of the cell row in ROT, then WB.
// Remove all: EXEC (mark), then CAPACITY odd-even swap rounds in SWAP, then WB.
// One command in flight: a new beat is accepted only once the previous result is
// registered, and write-back waits while an earlier result is held for m_tready.
// Reset clears entry count and control; stored keys are undefined until written.
`default_nettype none

module bounded_deque_search_engine #(
    parameter int CAPACITY = bdqs_pkg::CAPACITY_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [bdqs_pkg::S_TDATA_W-1:0]    s_tdata,   // command[2:0], key[34:3]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [bdqs_pkg::M_TDATA_W-1:0]         m_tdata    // status[1:0], value[33:2],
                                                              // position[39:34],
                                                              // occupancy[46:40]
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(CAPACITY);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_ROT  = 5'b00100,
        ST_SWAP = 5'b01000,
        ST_WB   = 5'b10000
    } state_t;

    state_t                                  state_reg, state_next;
    logic [bdqs_pkg::CMD_W-1:0]              cmd_reg;
    logic signed [bdqs_pkg::KEY_W-1:0]       key_reg;
    logic [CNT_W-1:0]                        count_reg, count_next;
    logic [IDX_W-1:0]                        step_reg, step_next;
    logic                                    found_reg, found_next;
    logic [bdqs_pkg::STATUS_W-1:0]           status_reg, status_next;
    logic signed [bdqs_pkg::KEY_W-1:0]       value_reg, value_next;
    logic [IDX_W-1:0]                        pos_reg, pos_next;
    logic                                    m_tvalid_reg, m_tvalid_next;
    logic [bdqs_pkg::M_TDATA_W-1:0]          m_tdata_reg, m_tdata_next;

    bdqs_pkg::cell_ctl_t                     ctl;
    logic signed [bdqs_pkg::KEY_W-1:0]       head_data;
    logic [CNT_W-1:0]                        kept;
    logic                                    out_free;
    logic [CNT_W-1:0]                        occ;

    bdqs_chain #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_chain (
        .clk       (clk),
        .ctl       (ctl),
        .count     (count_reg),
        .head_data (head_data),
        .kept      (kept)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign occ      = (cmd_reg == bdqs_pkg::CMD_REMOVE) ? kept : count_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        value_next    = value_reg;
        pos_next      = pos_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ctl.op        = bdqs_pkg::CELL_HOLD;
        ctl.phase     = step_reg[0];
        ctl.key       = key_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                status_next = bdqs_pkg::STS_OK;
                value_next  = '0;
                pos_next    = '0;
                found_next  = 1'b0;
                step_next   = '0;
                state_next  = ST_WB;
                case (cmd_reg)
                    bdqs_pkg::CMD_INS_HEAD:
                    begin
                        if (count_reg == CNT_FULL)
                        begin
                            status_next = bdqs_pkg::STS_FULL;
                        end
                        else
                        begin
                            ctl.op     = bdqs_pkg::CELL_SHR;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    bdqs_pkg::CMD_INS_TAIL:
                    begin
                        if (count_reg == CNT_FULL)
                        begin
                            status_next = bdqs_pkg::STS_FULL;
                        end
                        else
                        begin
                            ctl.op     = bdqs_pkg::CELL_LOAD;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    bdqs_pkg::CMD_DEL_HEAD:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bdqs_pkg::STS_EMPTY;
                        end
                        else
                        begin
                            ctl.op     = bdqs_pkg::CELL_SHL;
                            value_next = head_data;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    bdqs_pkg::CMD_DEL_TAIL:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bdqs_pkg::STS_EMPTY;
                        end
                        else
                        begin
                            state_next = ST_ROT;
                        end
                    end
                    bdqs_pkg::CMD_FIND:
                    begin
                        status_next = bdqs_pkg::STS_NOTFOUND;
                        state_next  = ST_ROT;
                    end
                    bdqs_pkg::CMD_REMOVE:
                    begin
                        ctl.op     = bdqs_pkg::CELL_MARK;
                        state_next = ST_SWAP;
                    end
                    bdqs_pkg::CMD_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_ROT:
            begin
                // full rotation: entry at offset step sits in the head cell
                ctl.op    = bdqs_pkg::CELL_SHL;
                step_next = step_reg + IDX_W'(1);
                if ((cmd_reg == bdqs_pkg::CMD_FIND) && !found_reg
                    && (CNT_W'(step_reg) < count_reg) && (head_data == key_reg))
                begin
                    found_next  = 1'b1;
                    status_next = bdqs_pkg::STS_OK;
                    pos_next    = step_reg;
                end
                if ((cmd_reg == bdqs_pkg::CMD_DEL_TAIL)
                    && (CNT_W'(step_reg) == count_reg - CNT_W'(1)))
                begin
                    value_next = head_data;
                end
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_WB;
                    if (cmd_reg == bdqs_pkg::CMD_DEL_TAIL)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            ST_SWAP:
            begin
                ctl.op    = bdqs_pkg::CELL_SWAP;
                step_next = step_reg + IDX_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (out_free)
                begin
                    count_next    = occ;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0,
                                     bdqs_pkg::OCC_W'(occ),
                                     bdqs_pkg::POS_W'(pos_reg),
                                     value_reg,
                                     status_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            step_reg     <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            step_reg     <= step_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tdata[bdqs_pkg::CMD_W-1:0];
            key_reg <= s_tdata[bdqs_pkg::CMD_W +: bdqs_pkg::KEY_W];
        end
        status_reg  <= status_next;
        value_reg   <= value_next;
        pos_reg     <= pos_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count above capacity");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted beat not executed");

    a_result_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_WB))
        else $error("result issued outside write-back");

    a_pass_length: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ROT || state_reg == ST_SWAP) && step_reg == STEP_LAST)
        |=> (state_reg == ST_WB))
        else $error("cell pass did not end after a full sweep");

endmodule

`default_nettype wire
